// File: rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and bitmap layout functions for the buddy page allocator.
package bpa_pkg;

  localparam int unsigned PAGES_DEF  = 4096;
  localparam int unsigned ORDERS_DEF = 11;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MAX_ORDERS = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOMEM   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_A_RD,
    FSM_A_CHK,
    FSM_S_RD,
    FSM_S_WR,
    FSM_M_RD,
    FSM_M_CHK
  } fsm_t;

  // Bitmap words taken by one order (each order starts on a word boundary).
  function automatic int unsigned words_at(int unsigned o, int unsigned pages);
    return ((pages >> o) + WORD_W - 1) >> 5;
  endfunction

  // First bitmap word of an order.
  function automatic int unsigned word_base(int unsigned o, int unsigned pages);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < o; k++) begin
      acc = acc + words_at(k, pages);
    end
    return acc;
  endfunction

endpackage

// File: rtl/core/bpa_map_ram.sv
`timescale 1ns / 1ps
// Free bitmap storage: one write port, one read port with registered data.
module bpa_map_ram #(
  parameter int unsigned AW    = 9,
  parameter int unsigned DEPTH = 258
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bpa_pkg::WORD_W-1:0]    wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [bpa_pkg::WORD_W-1:0]    rdata
);

  logic [bpa_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bpa_ffs.sv
`timescale 1ns / 1ps
// Find-first-set unit: lowest set bit of one bitmap word.
module bpa_ffs (
  input  logic [bpa_pkg::WORD_W-1:0] word,
  output logic                       hit,
  output logic [4:0]                 pos
);

  always_comb begin
    pos = '0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        pos = 5'(i);
      end
    end
  end

  assign hit = |word;

endmodule

// File: rtl/core/buddy_page_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the buddy page allocator: sequencer, bitmap memory and free page counter.
//
//   Channel   Ports                                           Direction  Handshake
//   input     in_mode, in_order, in_page_index                in         start && !busy
//   result    out_status, out_block_page, out_free_pages      out        out_valid, one cycle
//
// The free bitmap lives in a single memory of 32-bit words, one region per order,
// and one find-first-set unit plus one read-modify-write path do all the work.
// An allocate reads and then tests each bitmap word it scans, and reads and then
// writes one word per split level. A free reads and then checks one word per merge
// level. A request whose order is out of range, or a free whose page is out of
// range, finishes straight from idle. After reset a clearing pass writes zero to
// every bitmap word (258 at the defaults) with busy held high. The result strobe
// lasts one cycle and the receiver cannot stall it; busy drops in the same cycle.
module buddy_page_allocator_unit #(
  parameter int unsigned PAGES  = bpa_pkg::PAGES_DEF,
  parameter int unsigned ORDERS = bpa_pkg::ORDERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [3:0]  in_order,
  input  logic [11:0] in_page_index,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_block_page,
  output logic [12:0] out_free_pages
);

  localparam int unsigned WORDS = bpa_pkg::word_base(ORDERS, PAGES);
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned PW    = $clog2(PAGES);
  localparam int unsigned BW    = (PW < 5) ? 5 : PW;
  localparam int unsigned CW    = $clog2(PAGES + 1);
  localparam int unsigned OW    = 5;
  localparam int unsigned WW    = bpa_pkg::WORD_W;

  // Per-order constants: first word, block count and word count.
  logic [AW-1:0] base_tab [bpa_pkg::MAX_ORDERS];
  logic [31:0]   n_tab    [bpa_pkg::MAX_ORDERS];
  logic [AW:0]   nw_tab   [bpa_pkg::MAX_ORDERS];

  for (genvar g = 0; g < bpa_pkg::MAX_ORDERS; g++) begin : g_tab
    assign base_tab[g] = AW'(bpa_pkg::word_base(g, PAGES));
    assign n_tab[g]    = 32'(PAGES >> g);
    assign nw_tab[g]   = (AW + 1)'(bpa_pkg::words_at(g, PAGES));
  end

  bpa_pkg::fsm_t state_r, state_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic [3:0]    ord_r, ord_nxt;
  logic [AW-1:0] w_r, w_nxt;
  logic [BW-1:0] blk_r, blk_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          first_r, first_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [AW-1:0] clr_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [11:0]   out_page_r;
  logic [12:0]   out_free_r;

  // Completion of the current item, decided in the datapath block.
  logic                fin;
  bpa_pkg::status_t    fin_status;
  logic [11:0]         fin_page;

  // Memory access.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  logic          ffs_hit;
  logic [4:0]    ffs_pos;

  bpa_map_ram #(
    .AW    (AW),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bpa_ffs u_ffs (
    .word (mem_rdata),
    .hit  (ffs_hit),
    .pos  (ffs_pos)
  );

  // Decision terms shared by the next-state and datapath logic.
  logic          accept;
  logic          order_bad;
  logic [31:0]   blk_in;
  logic          free_bad;
  logic          a_more_w;
  logic          a_more_o;
  logic          o_at_req;
  logic          own_bit;
  logic [BW-1:0] bud;
  logic          merge;
  logic [BW-1:0] blk_found;
  logic [CW-1:0] size;

  assign accept    = start && (state_r == bpa_pkg::FSM_IDLE);
  assign order_bad = {1'b0, in_order} >= OW'(ORDERS);
  assign blk_in    = 32'(in_page_index) >> in_order;
  assign free_bad  = blk_in >= n_tab[in_order];
  assign a_more_w  = ({1'b0, w_r} + (AW + 1)'(1)) < nw_tab[o_r[3:0]];
  assign a_more_o  = (o_r + OW'(1)) < OW'(ORDERS);
  assign o_at_req  = o_r == {1'b0, ord_r};
  assign own_bit   = mem_rdata[blk_r[4:0]];
  assign bud       = blk_r ^ BW'(1);
  assign merge     = a_more_o && (32'(bud) < n_tab[o_r[3:0]]) && mem_rdata[bud[4:0]];
  assign blk_found = BW'((32'(w_r) << 5) | 32'(ffs_pos));
  assign size      = CW'(1) << ord_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::FSM_CLEAR: begin
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = bpa_pkg::FSM_IDLE;
        end
      end
      bpa_pkg::FSM_IDLE: begin
        if (accept && !order_bad) begin
          if (!in_mode) begin
            state_nxt = bpa_pkg::FSM_A_RD;
          end else if (!free_bad) begin
            state_nxt = bpa_pkg::FSM_M_RD;
          end
        end
      end
      bpa_pkg::FSM_A_RD: state_nxt = bpa_pkg::FSM_A_CHK;
      bpa_pkg::FSM_A_CHK: begin
        if (ffs_hit) begin
          state_nxt = o_at_req ? bpa_pkg::FSM_IDLE : bpa_pkg::FSM_S_RD;
        end else if (a_more_w || a_more_o) begin
          state_nxt = bpa_pkg::FSM_A_RD;
        end else begin
          state_nxt = bpa_pkg::FSM_IDLE;
        end
      end
      bpa_pkg::FSM_S_RD: state_nxt = bpa_pkg::FSM_S_WR;
      bpa_pkg::FSM_S_WR: begin
        state_nxt = o_at_req ? bpa_pkg::FSM_IDLE : bpa_pkg::FSM_S_RD;
      end
      bpa_pkg::FSM_M_RD: state_nxt = bpa_pkg::FSM_M_CHK;
      bpa_pkg::FSM_M_CHK: begin
        if (first_r && own_bit) begin
          state_nxt = bpa_pkg::FSM_IDLE;
        end else begin
          state_nxt = merge ? bpa_pkg::FSM_M_RD : bpa_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::FSM_IDLE;
    endcase
  end

  // Datapath, memory control and completion.
  always_comb begin
    logic [OW-1:0] o_dec;
    logic [BW-1:0] blk_sh;
    o_dec      = o_r - OW'(1);
    blk_sh     = blk_r << 1;
    o_nxt      = o_r;
    ord_nxt    = ord_r;
    w_nxt      = w_r;
    blk_nxt    = blk_r;
    addr_nxt   = addr_r;
    first_nxt  = first_r;
    total_nxt  = total_r;
    fin        = 1'b0;
    fin_status = bpa_pkg::ST_OK;
    fin_page   = '0;
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = addr_r;
    unique case (state_r)
      bpa_pkg::FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      bpa_pkg::FSM_IDLE: begin
        ord_nxt   = in_order;
        o_nxt     = {1'b0, in_order};
        w_nxt     = '0;
        blk_nxt   = BW'(blk_in);
        first_nxt = 1'b1;
        if (accept) begin
          if (order_bad || (in_mode && free_bad)) begin
            fin        = 1'b1;
            fin_status = bpa_pkg::ST_INVALID;
          end
        end
      end
      bpa_pkg::FSM_A_RD: begin
        mem_raddr = base_tab[o_r[3:0]] + w_r;
        addr_nxt  = mem_raddr;
      end
      bpa_pkg::FSM_A_CHK: begin
        if (ffs_hit) begin
          // Take the block out of the map; splitting follows if needed.
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(WW'(1) << ffs_pos);
          blk_nxt   = blk_found;
          if (o_at_req) begin
            fin       = 1'b1;
            fin_page  = 12'(32'(blk_found) << ord_r);
            total_nxt = (total_r >= size) ? total_r - size : '0;
          end
        end else if (a_more_w) begin
          w_nxt = w_r + AW'(1);
        end else if (a_more_o) begin
          w_nxt = '0;
          o_nxt = o_r + OW'(1);
        end else begin
          fin        = 1'b1;
          fin_status = bpa_pkg::ST_NOMEM;
        end
      end
      bpa_pkg::FSM_S_RD: begin
        // Step down one order; the upper half of the split becomes free.
        mem_raddr = base_tab[o_dec[3:0]] + AW'(blk_sh >> 5);
        addr_nxt  = mem_raddr;
        o_nxt     = o_dec;
        blk_nxt   = blk_sh;
      end
      bpa_pkg::FSM_S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | (WW'(1) << {blk_r[4:1], 1'b1});
        if (o_at_req) begin
          fin       = 1'b1;
          fin_page  = 12'(32'(blk_r) << ord_r);
          total_nxt = (total_r >= size) ? total_r - size : '0;
        end
      end
      bpa_pkg::FSM_M_RD: begin
        mem_raddr = base_tab[o_r[3:0]] + AW'(blk_r >> 5);
        addr_nxt  = mem_raddr;
      end
      bpa_pkg::FSM_M_CHK: begin
        // Block and buddy share one word, so one read serves both bits.
        if (first_r && own_bit) begin
          fin        = 1'b1;
          fin_status = bpa_pkg::ST_INVALID;
        end else if (merge) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata & ~(WW'(1) << bud[4:0]);
          blk_nxt   = blk_r >> 1;
          o_nxt     = o_r + OW'(1);
          first_nxt = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | (WW'(1) << blk_r[4:0]);
          fin       = 1'b1;
          if ((CW + 1)'(total_r) + (CW + 1)'(size) > (CW + 1)'(PAGES)) begin
            total_nxt = CW'(PAGES);
          end else begin
            total_nxt = total_r + size;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::FSM_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= fin;
      if (state_r == bpa_pkg::FSM_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    o_r     <= o_nxt;
    ord_r   <= ord_nxt;
    w_r     <= w_nxt;
    blk_r   <= blk_nxt;
    addr_r  <= addr_nxt;
    first_r <= first_nxt;
    if (fin) begin
      out_status_r <= fin_status;
      out_page_r   <= fin_page;
      out_free_r   <= 13'(total_nxt);
    end
  end

  assign busy           = state_r != bpa_pkg::FSM_IDLE;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block_page = out_page_r;
  assign out_free_pages = out_free_r;

endmodule

// File: rtl/core/bpa_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the buddy page allocator and its bind to the top level.
module bpa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [11:0] out_block_page,
  input logic [12:0] out_free_pages
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither started work nor finished");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the block is busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == bpa_pkg::ST_OK || out_status == bpa_pkg::ST_INVALID ||
                    out_status == bpa_pkg::ST_NOMEM) &&
                   (out_free_pages <= 13'(bpa_pkg::PAGES_DEF))))
    else $error("undefined status code or free page count out of range");

  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bpa_pkg::ST_OK) |-> (out_block_page == 12'd0))
    else $error("block page set on a failed request");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !out_valid && !start) |=> !out_valid)
    else $error("result without an item");

endmodule

bind buddy_page_allocator_unit bpa_chk u_bpa_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_block_page (out_block_page),
  .out_free_pages (out_free_pages)
);
